FILE: sv/pca_pkg.sv
package pca_pkg;

  localparam int QW = 16;
  localparam int TW = 32;
  localparam int RW = 32;
  localparam int AW = 40;
  localparam int IN_DATA_W = 256;
  localparam int OUT_DATA_W = 96;
  localparam logic signed [RW-1:0] Q30_ONE = 32'sh4000_0000;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic load;      // capture the input item
    logic clear;     // return the pose to identity
    logic quat;      // build the new rotation from the quaternion
    logic mac;       // accumulate one product
    logic mac_first; // first product of a three-term sum
    logic rot_wr;    // finish a rotation entry
    logic tr_wr;     // finish a translation entry
    logic [1:0] row;
    logic [1:0] col;
    logic [1:0] k;
    logic commit;    // copy the new pose into the kept pose
    logic emit;      // build the result item
  } pca_cmd_t;

endpackage

FILE: sv/pca_dp.sv
module pca_dp (
  input  logic                      clk,
  input  pca_pkg::pca_cmd_t         cmd,
  input  logic                      rst_n,
  input  logic [pca_pkg::IN_DATA_W-1:0]  in_data,
  output logic [pca_pkg::OUT_DATA_W-1:0] res_data,
  output logic                      res_sat
);
  import pca_pkg::*;

  logic signed [QW-1:0] qx_r, qy_r, qz_r, qw_r;
  logic signed [TW-1:0] tn_r [3];
  logic signed [RW-1:0] rn_r [9];
  logic signed [RW-1:0] ra_r [9];
  logic signed [RW-1:0] rnew_r [9];
  logic signed [AW-1:0] ta_r [3];
  logic signed [AW-1:0] tnew_r [3];
  logic signed [66:0]   sum_r;
  logic signed [63:0]   prod;
  logic signed [RW-1:0] opa, opb;
  logic signed [66:0]   sum_nxt, rsum;
  logic signed [36:0]   q;
  logic signed [AW:0]   tsum;
  logic                 sat_r;
  logic                 sat_set;
  logic [3:0]           ai, ri, wi;

  // Quaternion products for the new rotation, exact in Q2.30.
  logic signed [33:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [35:0] e [9];

  always_comb begin
    xx = 34'(qx_r * qx_r); yy = 34'(qy_r * qy_r); zz = 34'(qz_r * qz_r);
    xy = 34'(qx_r * qy_r); xz = 34'(qx_r * qz_r); yz = 34'(qy_r * qz_r);
    wx = 34'(qw_r * qx_r); wy = 34'(qw_r * qy_r); wz = 34'(qw_r * qz_r);
    e[0] = 36'(Q30_ONE) - 36'(2 * (36'(yy) + 36'(zz)));
    e[1] = 36'(2 * (36'(xy) - 36'(wz)));
    e[2] = 36'(2 * (36'(xz) + 36'(wy)));
    e[3] = 36'(2 * (36'(xy) + 36'(wz)));
    e[4] = 36'(Q30_ONE) - 36'(2 * (36'(xx) + 36'(zz)));
    e[5] = 36'(2 * (36'(yz) - 36'(wx)));
    e[6] = 36'(2 * (36'(xz) - 36'(wy)));
    e[7] = 36'(2 * (36'(yz) + 36'(wx)));
    e[8] = 36'(Q30_ONE) - 36'(2 * (36'(xx) + 36'(yy)));
  end

  // One shared multiplier: R_acc[row][k] times R_new[k][col] or t_new[k].
  always_comb begin
    ai = 4'(cmd.row) * 4'd3 + 4'(cmd.k);
    ri = 4'(cmd.k) * 4'd3 + 4'(cmd.col);
    wi = 4'(cmd.row) * 4'd3 + 4'(cmd.col);
    opa = ra_r[ai];
    opb = (cmd.col == 2'd3) ? tn_r[cmd.k] : rn_r[ri];
    prod = opa * opb;
    sum_nxt = (cmd.mac_first ? 67'sd0 : sum_r) + 67'(prod);
    rsum = sum_r + 67'sd536870912;
    q = 37'(rsum >>> 30);
    tsum = 41'(ta_r[cmd.row]) + 41'(q);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qx_r <= in_data[16:1];
      qy_r <= in_data[32:17];
      qz_r <= in_data[48:33];
      qw_r <= in_data[64:49];
      tn_r[0] <= in_data[96:65];
      tn_r[1] <= in_data[128:97];
      tn_r[2] <= in_data[160:129];
    end
    if (cmd.mac) sum_r <= sum_nxt;
    if (cmd.quat) begin
      for (int i = 0; i < 9; i++) begin
        if (e[i] > 36'sh07FFF_FFFF) rn_r[i] <= 32'sh7FFF_FFFF;
        else if (e[i] < -36'sh08000_0000) rn_r[i] <= 32'sh8000_0000;
        else rn_r[i] <= e[i][31:0];
      end
    end
    if (cmd.rot_wr) begin
      if (q > 37'sh0_7FFF_FFFF) rnew_r[wi] <= 32'sh7FFF_FFFF;
      else if (q < -37'sh0_8000_0000) rnew_r[wi] <= 32'sh8000_0000;
      else rnew_r[wi] <= q[31:0];
    end
    if (cmd.tr_wr) begin
      if (tsum > 41'sh0_7F_FFFF_FFFF) tnew_r[cmd.row] <= 40'sh7F_FFFF_FFFF;
      else if (tsum < -41'sh0_80_0000_0000) tnew_r[cmd.row] <= 40'sh80_0000_0000;
      else tnew_r[cmd.row] <= tsum[AW-1:0];
    end
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < 9; i++) ra_r[i] <= (i % 4 == 0) ? Q30_ONE : '0;
      for (int i = 0; i < 3; i++) ta_r[i] <= '0;
    end else if (cmd.commit) begin
      ra_r <= rnew_r;
      ta_r <= tnew_r;
    end
    if (cmd.emit) begin
      for (int i = 0; i < 3; i++) begin
        if (ta_r[i] > 40'sh00_7FFF_FFFF) res_data[32*i +: 32] <= 32'h7FFF_FFFF;
        else if (ta_r[i] < -40'sh00_8000_0000) res_data[32*i +: 32] <= 32'h8000_0000;
        else res_data[32*i +: 32] <= ta_r[i][31:0];
      end
    end
  end

  // Clip flag for the item, gathered over all steps.
  always_comb begin
    sat_set = 1'b0;
    if (cmd.quat)
      for (int i = 0; i < 9; i++)
        if (e[i] > 36'sh07FFF_FFFF || e[i] < -36'sh08000_0000) sat_set = 1'b1;
    if (cmd.rot_wr && (q > 37'sh0_7FFF_FFFF || q < -37'sh0_8000_0000)) sat_set = 1'b1;
    if (cmd.tr_wr && (tsum > 41'sh0_7F_FFFF_FFFF || tsum < -41'sh0_80_0000_0000))
      sat_set = 1'b1;
    if (cmd.emit)
      for (int i = 0; i < 3; i++)
        if (ta_r[i] > 40'sh00_7FFF_FFFF || ta_r[i] < -40'sh00_8000_0000) sat_set = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load || cmd.clear) begin
      sat_r <= 1'b0;
    end else if (sat_set) begin
      sat_r <= 1'b1;
    end
  end

  assign res_sat = sat_r;
endmodule

FILE: sv/pca_ctrl.sv
module pca_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_first,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output pca_pkg::pca_cmd_t cmd
);
  import pca_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_QUAT, S_MAC, S_WR, S_COMMIT, S_EMIT, S_OUT} state_t;

  state_t     state_r;
  logic [1:0] row_r, col_r, k_r;
  logic       valid_r;

  assign in_tready  = (state_r == S_IDLE) && !valid_r;
  assign out_tvalid = valid_r;

  always_comb begin
    cmd = '0;
    cmd.row = row_r;
    cmd.col = col_r;
    cmd.k   = k_r;
    case (state_r)
      S_IDLE: begin
        cmd.load  = in_tvalid && in_tready;
        cmd.clear = in_tvalid && in_tready && in_first;
      end
      S_QUAT:   cmd.quat = 1'b1;
      S_MAC: begin
        cmd.mac = 1'b1;
        cmd.mac_first = (k_r == 2'd0);
      end
      S_WR: begin
        cmd.rot_wr = (col_r != 2'd3);
        cmd.tr_wr  = (col_r == 2'd3);
      end
      S_COMMIT: cmd.commit = 1'b1;
      S_EMIT:   cmd.emit = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      row_r <= '0; col_r <= '0; k_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (valid_r && out_tready) valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          row_r <= '0; col_r <= '0; k_r <= '0;
          state_r <= in_first ? S_EMIT : S_QUAT;
        end
        S_QUAT: state_r <= S_MAC;
        S_MAC: begin
          if (k_r == 2'd2) begin
            k_r <= '0;
            state_r <= S_WR;
          end else begin
            k_r <= k_r + 2'd1;
          end
        end
        S_WR: begin
          state_r <= S_MAC;
          if (col_r == 2'd3) begin
            col_r <= '0;
            if (row_r == 2'd2) state_r <= S_COMMIT;
            else row_r <= row_r + 2'd1;
          end else begin
            col_r <= col_r + 2'd1;
          end
        end
        S_COMMIT: state_r <= S_EMIT;
        S_EMIT:   state_r <= S_OUT;
        S_OUT: begin
          valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: sv/pose_chain_accumulator.sv
// Channel | Dir | Fields (tdata from bit 0 up)
// in_     | in  | first_in_chain, quat_x/y/z/w, trans_x/y/z (161 bits in 256)
// out_    | out | pos_x, pos_y, pos_z (96 bits); tuser: saturated
// An item runs twelve three-term sums through one shared
// 32x32 multiplier, one product per cycle, plus load, quaternion, write, commit and emit steps.
// A first-in-chain item resets the pose to identity and skips the sums.
// The result stays in an output register until taken; the next item is
// accepted once that register is empty. rst_n restores the identity pose.
module pose_chain_accumulator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [255:0] in_tdata,  // first_in_chain, quat_x, quat_y, quat_z, quat_w,
                                  // trans_x, trans_y, trans_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // pos_x, pos_y, pos_z
  output logic        out_tuser   // saturated
);
  import pca_pkg::*;

  pca_cmd_t cmd;

  pca_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_first(in_tdata[0]),
    .in_tready(in_tready), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cmd(cmd)
  );

  pca_dp u_dp (
    .clk(clk), .cmd(cmd), .rst_n(rst_n), .in_data(in_tdata),
    .res_data(out_tdata), .res_sat(out_tuser)
  );
endmodule

FILE: sv/pca_checker.sv
module pca_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata
);
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("out_tvalid dropped");
  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("out_tdata changed");
  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accept while result waits");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("accept twice");
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid) else $error("result too early");
endmodule

bind pose_chain_accumulator pca_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
